// ===== hdl/imh_pkg.sv =====
// package for the indexed min-heap core: widths, modes, status codes
// no dependencies
package imh_pkg;
    localparam int MAX_NODES_DEF     = 256;
    localparam int PRIORITY_BITS_DEF = 32;
    localparam int NODE_W = $clog2(MAX_NODES_DEF + 1);
    localparam int PRIO_W = PRIORITY_BITS_DEF;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [1:0] {
        MODE_RESTART = 2'd0,
        MODE_EXTRACT = 2'd1,
        MODE_DECREASE = 2'd2,
        MODE_LOOKUP = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_ABSENT = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 1'b1;

    typedef struct packed {
        logic [1:0]        mode;
        logic [NODE_W-1:0] node_id;
        logic [PRIO_W-1:0] new_priority;
    } t_req;

    typedef struct packed {
        logic [NODE_W-1:0] result_node;
        logic [PRIO_W-1:0] result_priority;
        logic [NODE_W-1:0] result_position;
        logic [NODE_W-1:0] root_node;
        logic [NODE_W-1:0] remaining;
        logic [1:0]        status;
    } t_rsp;
endpackage

// ===== hdl/imh_if.sv =====
// valid/ready channel carrying one payload
// depends on nothing
interface imh_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/indexed_min_heap_decrease_key_core.sv =====
// Indexed binary min-heap with position map. One transaction at a time; a
// single sequencer drives one shared priority comparator and three single-port
// memories (slot node, slot priority, node position), one access each a cycle.
// The input is not ready while an operation runs or while a result waits.
// A lookup reads the node's position and then its slot; a decrease finds the
// node and climbs one level at a time until it stops; an extract takes the root
// and sinks the moved entry one level at a time until it stops. Restart clears
// all 2^AW position entries (512 at 256 nodes), fills count slots and sifts
// down count/2 slots. Widths and sizes come from imh_pkg. Depends on imh_pkg,
// imh_if, imh_ram.
module indexed_min_heap_decrease_key_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [imh_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [imh_pkg::NODE_W-1:0]  i_cfg_data,
    imh_if.sink                         in_ch,
    imh_if.source                       out_ch
);
    import imh_pkg::*;

    localparam int MAX_NODES     = MAX_NODES_DEF;
    localparam int PRIORITY_BITS = PRIORITY_BITS_DEF;
    localparam int AW = $clog2(MAX_NODES + 1);
    localparam int DEPTH = 1 << AW;
    localparam int CW = AW + 1;   // counts up to MAX_NODES and slot*2+1

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_RCLR   = 16'h0002,
        S_RFILL  = 16'h0004,
        S_SDRD   = 16'h0008,
        S_SDL    = 16'h0010,
        S_SDR    = 16'h0020,
        S_SDCMP  = 16'h0040,
        S_SWAP1  = 16'h0080,
        S_SWAP2  = 16'h0100,
        S_POSRD  = 16'h0200,
        S_POSWT  = 16'h0400,
        S_SLOTRD = 16'h0800,
        S_SUPAR  = 16'h1000,
        S_SUCMP  = 16'h2000,
        S_EXLAST = 16'h4000,
        S_DONE   = 16'h8000
    } t_state;

    t_state r_state, n_state;
    logic [NODE_W-1:0] r_src, r_cnt;
    logic [CW-1:0] r_heap, n_heap;
    logic [CW-1:0] r_i, n_i;            // generic counter / current slot
    logic [CW-1:0] r_b, n_b;            // build-loop slot
    logic [CW-1:0] r_s, n_s;            // swap partner
    logic [1:0] r_mode, n_mode;
    logic r_build, n_build;
    logic [NODE_W-1:0] r_id, n_id;
    logic [PRIORITY_BITS-1:0] r_np, n_np;
    // current element and best candidate
    logic [NODE_W-1:0] r_cn, n_cn, r_bn, n_bn;
    logic [PRIORITY_BITS-1:0] r_cp, n_cp, r_bp, n_bp;
    logic r_ovalid, n_ovalid;
    t_rsp r_rsp, n_rsp;

    // memories
    logic sn_we, sp_we, np_we;
    logic [AW-1:0] sn_a, sp_a, np_a;
    logic [NODE_W-1:0] sn_wd, sn_rd;
    logic [PRIORITY_BITS-1:0] sp_wd, sp_rd;
    logic [AW-1:0] np_wd, np_rd;

    imh_ram #(.WIDTH(NODE_W), .DEPTH(DEPTH)) u_sn (
        .i_clk(i_clk), .i_we(sn_we), .i_addr(sn_a), .i_wdata(sn_wd), .o_rdata(sn_rd));
    imh_ram #(.WIDTH(PRIORITY_BITS), .DEPTH(DEPTH)) u_sp (
        .i_clk(i_clk), .i_we(sp_we), .i_addr(sp_a), .i_wdata(sp_wd), .o_rdata(sp_rd));
    imh_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_np (
        .i_clk(i_clk), .i_we(np_we), .i_addr(np_a), .i_wdata(np_wd), .o_rdata(np_rd));

    // shared comparator
    logic [PRIORITY_BITS-1:0] cmp_a, cmp_b;
    logic cmp_lt;
    assign cmp_lt = cmp_a < cmp_b;

    logic [CW-1:0] cnt_sat;
    assign cnt_sat = ({1'b0, r_cnt} > CW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(r_cnt);
    logic [CW:0] lchild;
    assign lchild = {r_i, 1'b0};

    assign in_ch.ready = (r_state == S_IDLE) && !r_ovalid;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= NODE_W'(1);
            r_cnt <= NODE_W'(256);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_SOURCE) r_src <= i_cfg_data;
            else r_cnt <= i_cfg_data;
        end
    end

    logic id_ok;
    assign id_ok = (r_id >= NODE_W'(1)) && ({1'b0, r_id} <= (NODE_W+1)'(MAX_NODES));

    always_comb begin
        n_state = r_state; n_heap = r_heap; n_i = r_i; n_b = r_b; n_s = r_s;
        n_mode = r_mode; n_build = r_build; n_id = r_id; n_np = r_np;
        n_cn = r_cn; n_bn = r_bn; n_cp = r_cp; n_bp = r_bp;
        n_ovalid = r_ovalid; n_rsp = r_rsp;
        sn_we = 1'b0; sp_we = 1'b0; np_we = 1'b0;
        sn_a = AW'(r_i); sp_a = AW'(r_i); np_a = AW'(r_id);
        sn_wd = r_cn; sp_wd = r_cp; np_wd = AW'(r_i);
        cmp_a = r_bp; cmp_b = r_cp;
        if (out_ch.valid && out_ch.ready) n_ovalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_ch.valid && in_ch.ready) begin
                    n_mode = in_ch.data.mode;
                    n_id = in_ch.data.node_id;
                    n_np = in_ch.data.new_priority[PRIORITY_BITS-1:0];
                    n_rsp = '0;
                    n_build = 1'b0;
                    priority if (in_ch.data.mode == MODE_RESTART) begin
                        n_i = '0;
                        n_state = S_RCLR;
                    end else if (in_ch.data.mode == MODE_EXTRACT) begin
                        if (r_heap == '0) begin
                            n_rsp.status = ST_EMPTY;
                            n_state = S_DONE;
                        end else begin
                            n_i = CW'(1);
                            n_state = S_EXLAST;
                        end
                    end else begin
                        // nonzero slot makes the done path fetch the root
                        n_i = CW'(1);
                        n_state = S_POSRD;
                    end
                end
            end
            S_RCLR: begin   // clear all positions
                np_a = AW'(r_i); np_wd = '0; np_we = 1'b1;
                if (r_i == CW'(DEPTH - 1)) begin
                    n_i = CW'(1);
                    n_heap = cnt_sat;
                    n_state = (cnt_sat == '0) ? S_DONE : S_RFILL;
                end else n_i = r_i + CW'(1);
            end
            S_RFILL: begin
                sn_a = AW'(r_i); sn_wd = NODE_W'(r_i); sn_we = 1'b1;
                sp_a = AW'(r_i); sp_we = 1'b1;
                sp_wd = ({1'b0, r_src} == (NODE_W+1)'(r_i)) ? '0 : '1;
                np_a = AW'(r_i); np_wd = AW'(r_i); np_we = 1'b1;
                if (r_i == r_heap) begin
                    n_b = r_heap >> 1;
                    n_build = 1'b1;
                    if ((r_heap >> 1) == '0) n_state = S_DONE;
                    else begin n_i = r_heap >> 1; n_state = S_SDRD; end
                end else n_i = r_i + CW'(1);
            end
            S_SDRD: begin   // read current slot
                sn_a = AW'(r_i); sp_a = AW'(r_i);
                n_state = S_SDL;
            end
            S_SDL: begin
                n_cn = sn_rd; n_cp = sp_rd; n_bn = sn_rd; n_bp = sp_rd;
                n_s = r_i;
                if (lchild > (CW+1)'(r_heap)) n_state = S_SDCMP;
                else begin
                    sn_a = AW'(lchild); sp_a = AW'(lchild);
                    n_state = S_SDR;
                end
            end
            S_SDR: begin
                cmp_a = sp_rd; cmp_b = r_bp;
                if (cmp_lt) begin n_bn = sn_rd; n_bp = sp_rd; n_s = CW'(lchild); end
                if (lchild + 1'b1 <= (CW+1)'(r_heap)) begin
                    sn_a = AW'(lchild + 1'b1); sp_a = AW'(lchild + 1'b1);
                    n_state = S_SDCMP;
                    n_b = r_b;
                end else begin
                    n_state = S_SDCMP;
                end
            end
            S_SDCMP: begin
                if (lchild + 1'b1 <= (CW+1)'(r_heap)) begin
                    cmp_a = sp_rd; cmp_b = r_bp;
                    if (cmp_lt) begin
                        n_bn = sn_rd; n_bp = sp_rd; n_s = CW'(lchild + 1'b1);
                    end
                end
                n_state = S_SWAP1;
                if (!((lchild + 1'b1 <= (CW+1)'(r_heap)) && cmp_lt) && r_s == r_i)
                    n_state = S_SWAP2; // no move: finish
            end
            S_SWAP1: begin  // write best into current slot; S_SWAP2 then writes current into best slot
                sn_a = AW'(r_i); sn_wd = r_bn; sn_we = 1'b1;
                sp_a = AW'(r_i); sp_wd = r_bp; sp_we = 1'b1;
                np_a = AW'(r_bn); np_wd = AW'(r_i); np_we = 1'b1;
                n_state = S_SWAP2;
                n_i = r_s; n_s = r_i;
            end
            S_SWAP2: begin
                if (r_s != r_i && r_state == S_SWAP2 && r_bn != r_cn) begin
                    sn_a = AW'(r_i); sn_wd = r_cn; sn_we = 1'b1;
                    sp_a = AW'(r_i); sp_wd = r_cp; sp_we = 1'b1;
                    np_a = AW'(r_cn); np_wd = AW'(r_i); np_we = 1'b1;
                    n_bn = r_cn;
                    if (r_mode == MODE_DECREASE && !r_build) begin
                        n_state = S_SUPAR;
                    end else n_state = S_SDRD;
                end else begin
                    // sift finished at r_i
                    if (r_mode == MODE_DECREASE && !r_build) begin
                        n_rsp.result_position = NODE_W'(r_i);
                        n_state = S_DONE;
                    end else if (r_build && r_b > CW'(1)) begin
                        n_b = r_b - CW'(1); n_i = r_b - CW'(1);
                        n_state = S_SDRD;
                    end else n_state = S_DONE;
                end
            end
            S_EXLAST: begin  // read root and last, then move last into root
                if (r_i == CW'(1)) begin
                    sn_a = AW'(1); sp_a = AW'(1);
                    n_i = CW'(2);
                end else if (r_i == CW'(2)) begin
                    sn_a = AW'(r_heap); sp_a = AW'(r_heap);
                    n_rsp.result_node = sn_rd; n_rsp.result_priority = PRIO_W'(sp_rd);
                    n_i = CW'(3);
                end else begin
                    // move last into root; the extracted position is cleared in the done path
                    sn_a = AW'(1); sn_wd = sn_rd; sn_we = 1'b1;
                    sp_a = AW'(1); sp_wd = sp_rd; sp_we = 1'b1;
                    np_a = AW'(sn_rd); np_wd = AW'(1); np_we = 1'b1;
                    n_cn = sn_rd;
                    n_heap = r_heap - CW'(1);
                    n_i = CW'(1);
                    n_state = (r_heap == CW'(1)) ? S_SWAP2 : S_SDRD;
                    n_s = CW'(1);
                    n_bn = sn_rd;
                    n_b = '0;
                    n_build = 1'b0;
                    n_np = r_np;
                end
                if (r_i == CW'(3)) begin
                    // position of extracted node cleared later in the done path
                    n_id = r_rsp.result_node;
                end
            end
            S_POSRD: begin
                np_a = AW'(r_id);
                n_state = S_POSWT;
            end
            S_POSWT: begin
                n_rsp.result_node = r_id;
                if (!id_ok || np_rd == '0 || CW'(np_rd) > r_heap) begin
                    n_rsp.status = ST_ABSENT;
                    n_state = S_DONE;
                end else begin
                    n_i = CW'(np_rd);
                    sn_a = AW'(np_rd); sp_a = AW'(np_rd);
                    n_state = S_SLOTRD;
                end
            end
            S_SLOTRD: begin
                if (r_mode == MODE_LOOKUP) begin
                    n_rsp.result_priority = PRIO_W'(sp_rd);
                    n_rsp.result_position = NODE_W'(r_i);
                    n_state = S_DONE;
                end else begin
                    n_cn = sn_rd; n_cp = r_np;
                    sp_a = AW'(r_i); sp_wd = r_np; sp_we = 1'b1;
                    n_rsp.result_priority = PRIO_W'(r_np);
                    n_state = S_SUPAR;
                end
            end
            S_SUPAR: begin  // read parent
                if (r_i == CW'(1)) begin
                    n_rsp.result_position = NODE_W'(1);
                    n_state = S_DONE;
                end else begin
                    sn_a = AW'(r_i >> 1); sp_a = AW'(r_i >> 1);
                    n_state = S_SUCMP;
                end
            end
            S_SUCMP: begin
                cmp_a = r_np; cmp_b = sp_rd;
                if (cmp_lt) begin
                    // parent moves down, node moves up
                    sn_a = AW'(r_i); sn_wd = sn_rd; sn_we = 1'b1;
                    sp_a = AW'(r_i); sp_wd = sp_rd; sp_we = 1'b1;
                    np_a = AW'(sn_rd); np_wd = AW'(r_i); np_we = 1'b1;
                    n_i = r_i >> 1; n_s = r_i;
                    n_bn = sn_rd; n_cn = r_cn;
                    n_state = S_SWAP2; // writes node into parent slot
                end else begin
                    n_rsp.result_position = NODE_W'(r_i);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (r_mode == MODE_EXTRACT && r_rsp.status == ST_OK && r_id != '0) begin
                    np_a = AW'(r_id); np_wd = '0; np_we = 1'b1;
                    n_id = '0;
                end else if (r_heap != '0 && r_i != '0) begin
                    sn_a = AW'(1);
                    n_i = '0;
                end else begin
                    n_rsp.root_node = (r_heap == '0) ? '0 : sn_rd;
                    n_rsp.remaining = NODE_W'(r_heap);
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_heap <= '0;
            r_ovalid <= 1'b0;
            r_build <= 1'b0;
            r_i <= '0;
        end else begin
            r_state <= n_state;
            r_heap <= n_heap;
            r_ovalid <= n_ovalid;
            r_build <= n_build;
            r_i <= n_i;
        end
        r_b <= n_b; r_s <= n_s; r_mode <= n_mode; r_id <= n_id; r_np <= n_np;
        r_cn <= n_cn; r_bn <= n_bn; r_cp <= n_cp; r_bp <= n_bp;
        r_rsp <= n_rsp;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_state == S_IDLE)
        else $error("result pending outside idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heap <= CW'(MAX_NODES))
        else $error("heap count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !out_ch.ready) |=> $stable(r_rsp))
        else $error("result changed while stalled");
endmodule

// ===== hdl/imh_ram.sv =====
// generic single-port ram, registered read
// no dependencies
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for indexed_min_heap_decrease_key_core
// depends on imh_pkg, imh_if and the core rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import imh_pkg::*;

    localparam int NN = MAX_NODES_DEF;
    localparam logic [PRIO_W-1:0] PRIO_MAX = '1;
    localparam longint CYCLE_LIMIT = 3000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [NODE_W-1:0] i_cfg_data = '0;

    imh_if #(.T(t_req)) req_ch ();
    imh_if #(.T(t_rsp)) rsp_ch ();

    indexed_min_heap_decrease_key_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .in_ch(req_ch.sink), .out_ch(rsp_ch.source)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [NODE_W-1:0] h_node [0:NN];
    logic [PRIO_W-1:0] h_prio [0:NN];
    int unsigned h_pos [0:NN];
    int unsigned h_count;
    logic [NODE_W-1:0] cfg_source;
    logic [NODE_W-1:0] cfg_count;
    bit restarted;

    t_req pending_reqs [$];
    t_rsp expected_rsps [$];
    int errors = 0;
    bit stim_done = 1'b0;
    longint cycle_cnt = 0;
    int hold_off = 0;

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic [NODE_W-1:0] tn;
        logic [PRIO_W-1:0] tp;
        tn = h_node[a]; tp = h_prio[a];
        h_node[a] = h_node[b]; h_prio[a] = h_prio[b];
        h_node[b] = tn; h_prio[b] = tp;
        if (h_node[a] >= 1 && h_node[a] <= NN) h_pos[h_node[a]] = a;
        if (h_node[b] >= 1 && h_node[b] <= NN) h_pos[h_node[b]] = b;
    endfunction

    function automatic void sift_down(int unsigned p);
        int unsigned l, r, s;
        forever begin
            l = 2 * p; r = 2 * p + 1; s = p;
            if (l <= h_count && h_prio[l] < h_prio[s]) s = l;
            if (r <= h_count && h_prio[r] < h_prio[s]) s = r;
            if (s == p) break;
            swap_slots(p, s);
            p = s;
        end
    endfunction

    function automatic t_rsp heap_op(t_req q);
        t_rsp o;
        int unsigned pos, cnt, i;
        o = '0;
        pos = 0;
        if (q.mode != MODE_RESTART) begin
            if (q.node_id >= 1 && q.node_id <= NN) pos = h_pos[q.node_id];
            if (pos > h_count) pos = 0;
        end
        case (t_mode'(q.mode))
            MODE_RESTART: begin
                cnt = (cfg_count > NN) ? NN : cfg_count;
                for (i = 0; i <= NN; i++) h_pos[i] = 0;
                h_count = cnt;
                for (i = 1; i <= cnt; i++) begin
                    h_node[i] = NODE_W'(i);
                    h_pos[i] = i;
                    h_prio[i] = (i == cfg_source) ? '0 : PRIO_MAX;
                end
                for (i = cnt / 2; i >= 1; i--) sift_down(i);
            end
            MODE_EXTRACT: begin
                if (h_count == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    o.result_node = h_node[1];
                    o.result_priority = h_prio[1];
                    swap_slots(1, h_count);
                    h_count--;
                    h_pos[o.result_node] = 0;
                    sift_down(1);
                end
            end
            default: begin
                o.result_node = q.node_id;
                if (pos == 0) begin
                    o.status = ST_ABSENT;
                end else if (q.mode == MODE_DECREASE) begin
                    h_prio[pos] = q.new_priority;
                    while (pos > 1 && h_prio[pos] < h_prio[pos / 2]) begin
                        swap_slots(pos, pos / 2);
                        pos = pos / 2;
                    end
                    o.result_position = NODE_W'(pos);
                    o.result_priority = q.new_priority;
                end else begin
                    o.result_position = NODE_W'(pos);
                    o.result_priority = h_prio[pos];
                end
            end
        endcase
        o.root_node = (h_count != 0) ? h_node[1] : '0;
        o.remaining = NODE_W'(h_count);
        return o;
    endfunction

    // driver: predicts at acceptance
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (req_ch.valid && req_ch.ready) begin
            expected_rsps.push_back(heap_op(req_ch.data));
            send_gap = $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0) send_gap = 0;
            if (send_gap == 0 && pending_reqs.size() > 0) begin
                req_ch.data <= pending_reqs.pop_front();
            end else begin
                req_ch.valid <= 1'b0;
            end
        end else if (!req_ch.valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_reqs.size() > 0) begin
                req_ch.valid <= 1'b1;
                req_ch.data <= pending_reqs.pop_front();
            end
        end
    end

    // monitor and receiver stalls
    int recv_gap = 0;
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("unexpected transaction: node %0d", rsp_ch.data.result_node);
                    errors++;
                end else begin
                    t_rsp e;
                    e = expected_rsps.pop_front();
                    if (rsp_ch.data.result_node !== e.result_node) begin
                        $error("result_node exp %0d got %0d", e.result_node,
                               rsp_ch.data.result_node);
                        errors++;
                    end
                    if (rsp_ch.data.result_priority !== e.result_priority) begin
                        $error("result_priority exp %0h got %0h", e.result_priority,
                               rsp_ch.data.result_priority);
                        errors++;
                    end
                    if (rsp_ch.data.result_position !== e.result_position) begin
                        $error("result_position exp %0d got %0d", e.result_position,
                               rsp_ch.data.result_position);
                        errors++;
                    end
                    if (rsp_ch.data.root_node !== e.root_node) begin
                        $error("root_node exp %0d got %0d", e.root_node,
                               rsp_ch.data.root_node);
                        errors++;
                    end
                    if (rsp_ch.data.remaining !== e.remaining) begin
                        $error("remaining exp %0d got %0d", e.remaining,
                               rsp_ch.data.remaining);
                        errors++;
                    end
                    if (rsp_ch.data.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, rsp_ch.data.status);
                        errors++;
                    end
                end
                recv_gap = $urandom_range(0, 15);
                if ($urandom_range(0, 3) == 0) recv_gap = 0;
            end
            if (hold_off > 0) begin
                hold_off--;
                rsp_ch.ready <= 1'b0;
            end else if (recv_gap > 0 && !(rsp_ch.valid && rsp_ch.ready)) begin
                recv_gap--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= (recv_gap == 0);
                if (recv_gap > 0) recv_gap--;
            end
        end
    end

    task automatic push_req(t_mode m, int unsigned id, logic [PRIO_W-1:0] p);
        t_req q;
        q.mode = m;
        q.node_id = id[NODE_W-1:0];
        q.new_priority = p;
        pending_reqs.push_back(q);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v[NODE_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SOURCE) cfg_source = v[NODE_W-1:0];
        else cfg_count = v[NODE_W-1:0];
        @(posedge i_clk);
    endtask

    function automatic logic [PRIO_W-1:0] rand_prio();
        case ($urandom_range(0, 3))
            0: return PRIO_W'($urandom_range(0, 15));
            1: return PRIO_MAX - PRIO_W'($urandom_range(0, 3));
            default: return PRIO_W'($urandom());
        endcase
    endfunction

    // dijkstra-like phase: mostly decreases of present nodes and extracts
    task automatic run_phase(int n_items, int unsigned cnt);
        int k;
        int unsigned r;
        push_req(MODE_RESTART, 0, $urandom());
        for (k = 0; k < n_items; k++) begin
            r = $urandom_range(0, 99);
            if (r < 30) push_req(MODE_EXTRACT, $urandom_range(0, 511), $urandom());
            else if (r < 70) push_req(MODE_DECREASE, $urandom_range(1, cnt), rand_prio());
            else if (r < 80) push_req(MODE_DECREASE, $urandom_range(0, 511), rand_prio());
            else if (r < 97) push_req(MODE_LOOKUP, $urandom_range(0, 511), $urandom());
            else push_req(MODE_RESTART, $urandom_range(0, 511), $urandom());
        end
    endtask

    initial begin
        int p;
        int unsigned c;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        cfg_source = 1;
        cfg_count = 256;
        h_count = 0;
        for (int i = 0; i <= NN; i++) h_pos[i] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty extract, default restart, extremes
        push_req(MODE_EXTRACT, 0, '0);
        push_req(MODE_RESTART, 0, '0);
        push_req(MODE_LOOKUP, 1, '0);
        push_req(MODE_LOOKUP, 256, '0);
        push_req(MODE_LOOKUP, 0, '0);
        push_req(MODE_LOOKUP, 511, '0);
        push_req(MODE_DECREASE, 256, '0);
        push_req(MODE_DECREASE, 128, PRIO_MAX);
        push_req(MODE_DECREASE, 0, 32'h5);
        push_req(MODE_EXTRACT, 511, PRIO_MAX);
        push_req(MODE_DECREASE, 1, 32'h7);
        push_req(MODE_LOOKUP, 1, '0);
        push_req(MODE_DECREASE, 200, 32'h7);
        push_req(MODE_EXTRACT, 0, '0);
        push_req(MODE_DECREASE, 256, 32'h1);
        push_req(MODE_DECREASE, 100, 32'hAAAA_5555);
        push_req(MODE_DECREASE, 100, 32'h5555_AAAA);
        wait_drained();

        // count 0, source 0: empty heap
        write_cfg(CFG_COUNT, 0);
        write_cfg(CFG_SOURCE, 0);
        push_req(MODE_RESTART, 0, '0);
        push_req(MODE_EXTRACT, 0, '0);
        push_req(MODE_LOOKUP, 3, '0);
        wait_drained();
        // count above max saturates, source above count
        write_cfg(CFG_COUNT, 511);
        write_cfg(CFG_SOURCE, 300);
        push_req(MODE_RESTART, 0, '0);
        push_req(MODE_EXTRACT, 0, '0);
        push_req(MODE_LOOKUP, 256, '0);
        wait_drained();
        write_cfg(CFG_COUNT, 1);
        write_cfg(CFG_SOURCE, 1);
        push_req(MODE_RESTART, 0, '0);
        push_req(MODE_EXTRACT, 0, '0);
        push_req(MODE_EXTRACT, 0, '0);
        push_req(MODE_LOOKUP, 1, '0);
        wait_drained();

        // random phases, mostly small heaps
        for (p = 0; p < 14; p++) begin
            case (p % 4)
                0: c = $urandom_range(2, 12);
                1: c = $urandom_range(1, 40);
                2: c = (p == 6) ? 256 : $urandom_range(13, 64);
                default: c = $urandom_range(2, 20);
            endcase
            write_cfg(CFG_COUNT, c);
            write_cfg(CFG_SOURCE, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511)
                                                              : $urandom_range(1, c));
            run_phase(60, c);
            // long receiver stall while the sender keeps offering
            if (p == 3) hold_off = 600;
            wait_drained();
        end
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("testbench failed");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/imh_pkg.sv
hdl/imh_if.sv
hdl/imh_ram.sv
hdl/indexed_min_heap_decrease_key_core.sv
tb/testbench.sv
